@@ sv/lgge_pkg.sv @@
package lgge_pkg;

    // Grid geometry
    localparam int GRID_COLUMNS = 64;
    localparam int GRID_ROWS    = 64;
    localparam int COL_W        = $clog2(GRID_COLUMNS);
    localparam int ROW_W        = $clog2(GRID_ROWS);

    // Item field widths
    localparam int ACTION_W = 2;
    localparam int COORD_W  = 6;

    // Neighbor count and B3/S23 thresholds
    localparam int          NBR_W      = 4;
    localparam logic [3:0]  NBR_BIRTH  = 4'd3;
    localparam logic [3:0]  NBR_KEEP   = 4'd2;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_RD,
        S_WR_MOD,
        S_RD_RD,
        S_RD_OUT,
        S_ST_LAST,
        S_ST_FIRST,
        S_ST_SECOND,
        S_ST_RUN
    } state_t;

    // Row address source for the memory read port
    typedef enum logic [2:0] {
        RD_ITEM,
        RD_LAST,
        RD_FIRST,
        RD_SECOND,
        RD_AHEAD
    } rd_src_t;

    typedef struct packed {
        logic    capture;
        logic    clr_wr;
        logic    rd_en;
        rd_src_t rd_src;
        logic    load_prev;
        logic    load_cur;
        logic    run;
        logic    cell_wr;
        logic    emit_read;
        logic    emit_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rc_last;
    } dp_status_t;

endpackage

@@ sv/lgge_ctrl.sv @@
module lgge_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lgge_pkg::ACTION_W-1:0]    action,
    input  lgge_pkg::dp_status_t             sts,
    output lgge_pkg::ctrl_cmd_t              cmd,
    output logic                             busy
);
    import lgge_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.rc_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (action_t'(action))
                        ACT_WRITE: state_next = S_WR_RD;
                        ACT_STEP:  state_next = S_ST_LAST;
                        ACT_READ:  state_next = S_RD_RD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_WR_RD:     state_next = S_WR_MOD;
            S_WR_MOD:    state_next = S_IDLE;
            S_RD_RD:     state_next = S_RD_OUT;
            S_RD_OUT:    state_next = S_IDLE;
            S_ST_LAST:   state_next = S_ST_FIRST;
            S_ST_FIRST:  state_next = S_ST_SECOND;
            S_ST_SECOND: state_next = S_ST_RUN;
            S_ST_RUN:
            begin
                if (sts.rc_last)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        cmd.rd_src = RD_ITEM;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_CLEAR:  cmd.clr_wr = 1'b1;
            S_IDLE:   cmd.capture = start;
            S_WR_RD,
            S_RD_RD:  cmd.rd_en = 1'b1;
            S_WR_MOD: cmd.cell_wr = 1'b1;
            S_RD_OUT: cmd.emit_read = 1'b1;
            S_ST_LAST:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_LAST;
            end
            S_ST_FIRST:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_src    = RD_FIRST;
                cmd.load_prev = 1'b1;
            end
            S_ST_SECOND:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_src   = RD_SECOND;
                cmd.load_cur = 1'b1;
            end
            S_ST_RUN:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_src    = RD_AHEAD;
                cmd.run       = 1'b1;
                cmd.emit_step = sts.rc_last;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_step_done_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> (sts.rc_last && state_reg == S_ST_RUN))
        else $error("step completion before last row");

    a_clear_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && sts.rc_last) |=> (state_reg == S_IDLE))
        else $error("clear pass did not end in idle");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_WRITE || action == ACT_STEP
            || action == ACT_READ)) |=> busy)
        else $error("accepted word did not start work");
`endif

endmodule

@@ sv/lgge_datapath.sv @@
module lgge_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lgge_pkg::ctrl_cmd_t             cmd,
    input  logic [lgge_pkg::COORD_W-1:0]    column,
    input  logic [lgge_pkg::COORD_W-1:0]    row,
    input  logic                            cell_value,
    output lgge_pkg::dp_status_t            sts,
    output logic                            result_valid,
    output logic                            result_kind,
    output logic                            cell_state
);
    import lgge_pkg::*;

    // Grid held one row per word
    logic [GRID_COLUMNS-1:0] mem [GRID_ROWS];

    logic [COORD_W-1:0]      col_reg;
    logic [COORD_W-1:0]      row_reg;
    logic                    val_reg;
    logic [ROW_W-1:0]        rc_reg;
    logic [GRID_COLUMNS-1:0] rd_data_reg;
    logic [GRID_COLUMNS-1:0] prev_reg;
    logic [GRID_COLUMNS-1:0] cur_reg;
    logic [GRID_COLUMNS-1:0] first_reg;
    logic                    valid_reg;
    logic                    kind_reg;
    logic                    state_reg;

    logic                    in_grid;
    logic [COL_W-1:0]        col_idx;
    logic [ROW_W-1:0]        row_idx;
    logic                    rc_last;
    logic [ROW_W:0]          ahead;
    logic                    ahead_ok;
    logic                    rd_go;
    logic [ROW_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [ROW_W-1:0]        wr_addr;
    logic [GRID_COLUMNS-1:0] wr_data;
    logic [GRID_COLUMNS-1:0] mod_row;
    logic [GRID_COLUMNS-1:0] below_row;
    logic [GRID_COLUMNS-1:0] new_row;

    assign in_grid = (32'(col_reg) < GRID_COLUMNS) && (32'(row_reg) < GRID_ROWS);
    assign col_idx = COL_W'(col_reg);
    assign row_idx = ROW_W'(row_reg);
    assign rc_last = (rc_reg == ROW_W'(GRID_ROWS - 1));
    assign ahead   = {1'b0, rc_reg} + (ROW_W + 1)'(2);
    assign ahead_ok = (32'(ahead) < GRID_ROWS);

    assign sts.rc_last = rc_last;

    always_comb
    begin
        rd_go   = cmd.rd_en;
        rd_addr = row_idx;
        unique case (cmd.rd_src)
            RD_ITEM:   rd_addr = row_idx;
            RD_LAST:   rd_addr = ROW_W'(GRID_ROWS - 1);
            RD_FIRST:  rd_addr = '0;
            RD_SECOND: rd_addr = ROW_W'(1);
            RD_AHEAD:
            begin
                rd_addr = ROW_W'(ahead);
                rd_go   = cmd.rd_en && ahead_ok;
            end
            default:   rd_addr = row_idx;
        endcase
    end

    // Below neighbor of the last row is the saved original first row
    assign below_row = rc_last ? first_reg : rd_data_reg;

    for (genvar c = 0; c < GRID_COLUMNS; c++)
    begin : g_cell
        localparam int CL = (c + GRID_COLUMNS - 1) % GRID_COLUMNS;
        localparam int CR = (c + 1) % GRID_COLUMNS;
        logic [NBR_W-1:0] nbr;
        assign nbr = NBR_W'(prev_reg[CL]) + NBR_W'(prev_reg[c]) + NBR_W'(prev_reg[CR])
                   + NBR_W'(cur_reg[CL])  + NBR_W'(cur_reg[CR])
                   + NBR_W'(below_row[CL]) + NBR_W'(below_row[c]) + NBR_W'(below_row[CR]);
        assign new_row[c] = (nbr == NBR_BIRTH) || (cur_reg[c] && (nbr == NBR_KEEP));
    end

    always_comb
    begin
        mod_row          = rd_data_reg;
        mod_row[col_idx] = val_reg;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rc_reg;
        wr_data = new_row;
        priority if (cmd.clr_wr)
        begin
            wr_en   = 1'b1;
            wr_data = '0;
        end
        else if (cmd.run)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.cell_wr)
        begin
            wr_en   = in_grid;
            wr_addr = row_idx;
            wr_data = mod_row;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_go)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= column;
            row_reg <= row;
            val_reg <= cell_value;
        end
        if (cmd.load_prev)
            prev_reg <= rd_data_reg;
        if (cmd.load_cur)
        begin
            cur_reg   <= rd_data_reg;
            first_reg <= rd_data_reg;
        end
        if (cmd.run)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_data_reg;
        end
        if (cmd.emit_read)
        begin
            kind_reg  <= KIND_READ;
            state_reg <= in_grid ? rd_data_reg[col_idx] : 1'b0;
        end
        else if (cmd.emit_step)
        begin
            kind_reg  <= KIND_STEP;
            state_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr || cmd.run)
                rc_reg <= rc_last ? '0 : rc_reg + ROW_W'(1);
            valid_reg <= cmd.emit_read || cmd.emit_step;
        end
    end

    assign result_valid = valid_reg;
    assign result_kind  = kind_reg;
    assign cell_state   = state_reg;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held two cycles");

    a_step_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_STEP) |-> !cell_state)
        else $error("step completion carries cell state");

    a_row_count_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.clr_wr || cmd.run) && rc_last) |=> (rc_reg == '0))
        else $error("row counter did not wrap");
`endif

endmodule

@@ sv/life_grid_generation_engine_core.sv @@
// Port group  Signals                               Dir  Notes
// control     start, busy                           in/out word taken when start && !busy
// item        action, column, row, cell_value       in   sampled with start
// result      result_valid, result_kind, cell_state out  one-cycle strobe, no back-pressure
//
// After reset the grid is cleared one row a cycle; busy stays high until the last row is written.
// Cell write: busy for a row read, then a row write back. Cell read: busy for a row read,
// then the output; the result strobe comes in the same cycle that busy drops.
// Generation step: after priming reads, one whole row per cycle through the single
// read and single write port of the row memory; completion strobe follows the last row.
// Results cannot be stalled; the next word may be taken while a result is on the ports.
module life_grid_generation_engine_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lgge_pkg::ACTION_W-1:0]   action,
    input  logic [lgge_pkg::COORD_W-1:0]    column,
    input  logic [lgge_pkg::COORD_W-1:0]    row,
    input  logic                            cell_value,
    output logic                            result_valid,
    output logic                            result_kind,
    output logic                            cell_state
);
    import lgge_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    lgge_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    lgge_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .column       (column),
        .row          (row),
        .cell_value   (cell_value),
        .sts          (sts),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .cell_state   (cell_state)
    );

endmodule
